[sv/iplpr_pkg.sv]
// Types, constants and helper functions shared by the IPv4 route table block.
package iplpr_pkg;

  // Table geometry and field widths.
  localparam int MAX_ROUTES = 16;
  localparam int IDX_W      = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int ADDR_W     = 32;
  localparam int LEN_W      = 6;
  localparam int PORT_W     = 3;
  localparam int TTL_W      = 8;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ROUTES - 1);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(ADDR_W);
  localparam logic [TTL_W-1:0] TTL_ONE  = TTL_W'(1);

  typedef enum logic [0:0] {
    ACT_ADD   = 1'b0,
    ACT_ROUTE = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    ST_ADDED   = 3'd0,
    ST_DUP     = 3'd1,
    ST_FULL    = 3'd2,
    ST_FWD     = 3'd3,
    ST_TTL     = 3'd4,
    ST_NOROUTE = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
    logic              has_hop;
    logic [ADDR_W-1:0] hop_addr;
  } entry_t;

  // Input transaction payload.
  typedef struct packed {
    action_e           action;
    logic [ADDR_W-1:0] route_prefix_in;
    logic [LEN_W-1:0]  prefix_len_in;
    logic              has_hop_in;
    logic [ADDR_W-1:0] hop_addr_in;
    logic [PORT_W-1:0] port_in;
    logic [ADDR_W-1:0] dst_addr;
    logic [TTL_W-1:0]  ttl_in;
  } in_t;

  // Output transaction payload.
  typedef struct packed {
    status_e           status;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] out_hop_addr;
    logic [TTL_W-1:0]  out_ttl;
  } out_t;

  // Search key presented to the table while it is scanned.
  typedef struct packed {
    logic              is_add;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] dst;
  } key_t;

  // Control from the sequencer to the table.
  typedef struct packed {
    logic             start;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_entry;
  } scan_ctl_t;

  // Outcome of a full scan.
  typedef struct packed {
    logic             dup;
    logic             slot_ok;
    logic [IDX_W-1:0] slot;
    logic             found;
    entry_t           best;
  } scan_res_t;

  // Clamp a prefix length to the address width.
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    return (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  // Mask with the given number of high-order ones.
  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [ADDR_W-1:0] ones;
    ones = '1;
    return (len >= MAX_LEN) ? ones : ~(ones >> len);
  endfunction

endpackage

[sv/iplpr_in_if.sv]
// Valid/ready channel that carries input transactions.
interface iplpr_in_if
  import iplpr_pkg::*;
();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/iplpr_out_if.sv]
// Valid/ready channel that carries result transactions.
interface iplpr_out_if
  import iplpr_pkg::*;
();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/iplpr_table.sv]
// Route memory with valid bits and the per-entry compare that runs during a scan.
module iplpr_table
  import iplpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_ctl_t ctl_i,
  input  key_t      key_i,
  output scan_res_t res_o
);

  entry_t           mem [MAX_ROUTES];
  entry_t           rd_data_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [MAX_ROUTES-1:0] valid_q;

  logic             dup_q, dup_d;
  logic             slot_ok_q, slot_ok_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             found_q, found_d;
  entry_t           best_q, best_d;

  logic hit_valid;
  logic match;

  // Synchronous memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.wr_addr] <= ctl_i.wr_entry;
    end
    if (ctl_i.rd_en) begin
      rd_data_q <= mem[ctl_i.rd_addr];
    end
  end

  // Track which read data is arriving and which entries hold a route.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_idx_q <= '0;
      valid_q  <= '0;
    end else begin
      rd_vld_q <= ctl_i.rd_en;
      if (ctl_i.rd_en) begin
        rd_idx_q <= ctl_i.rd_addr;
      end
      if (ctl_i.wr_en) begin
        valid_q[ctl_i.wr_addr] <= 1'b1;
      end
    end
  end

  assign hit_valid = valid_q[rd_idx_q];
  assign match     = (key_i.dst & len_mask(rd_data_q.len)) == rd_data_q.prefix;

  // Fold one entry per cycle into the duplicate, free-slot and best-match state.
  always_comb begin
    dup_d     = dup_q;
    slot_ok_d = slot_ok_q;
    slot_d    = slot_q;
    found_d   = found_q;
    best_d    = best_q;
    if (ctl_i.start) begin
      dup_d     = 1'b0;
      slot_ok_d = 1'b0;
      found_d   = 1'b0;
    end else if (rd_vld_q) begin
      if (hit_valid) begin
        if (key_i.is_add) begin
          if (rd_data_q.len == key_i.len && rd_data_q.prefix == key_i.prefix) begin
            dup_d = 1'b1;
          end
        end else if (match && (!found_q || rd_data_q.len > best_q.len)) begin
          found_d = 1'b1;
          best_d  = rd_data_q;
        end
      end else if (!slot_ok_q) begin
        slot_ok_d = 1'b1;
        slot_d    = rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dup_q     <= 1'b0;
      slot_ok_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      dup_q     <= dup_d;
      slot_ok_q <= slot_ok_d;
      found_q   <= found_d;
    end
  end

  // Payload of the accumulators needs no reset.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    best_q <= best_d;
  end

  assign res_o.dup     = dup_q;
  assign res_o.slot_ok = slot_ok_q;
  assign res_o.slot    = slot_q;
  assign res_o.found   = found_q;
  assign res_o.best    = best_q;

endmodule

[sv/ipv4_longest_prefix_router.sv]
// A route transaction with an expired TTL skips the table scan and goes straight to its result.
// One transaction is handled at a time; each one is paced by the scan of the
// route memory through its single read port, one entry per cycle.
// A new transaction is taken while the previous result still waits in the output register.
// Reset (asynchronous, active low) empties the table at once by clearing the valid bits.
module ipv4_longest_prefix_router
  import iplpr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  iplpr_in_if.sink    in_i,
  iplpr_out_if.source out_o
);

  state_e state_q, state_d;
  in_t    req_q;
  logic [IDX_W-1:0] rd_addr_q, rd_addr_d;
  logic   out_valid_q;
  out_t   out_data_q;

  logic      in_accept;
  logic      out_free;
  logic      ttl_dead_in;
  logic      is_add;
  logic      ttl_dead;
  key_t      key;
  scan_ctl_t ctl;
  scan_res_t res;
  out_t      result;
  entry_t    new_entry;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_accept   = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign ttl_dead_in = (in_i.data.action == ACT_ROUTE) && (in_i.data.ttl_in <= TTL_ONE);

  assign is_add   = (req_q.action == ACT_ADD);
  assign ttl_dead = (req_q.ttl_in <= TTL_ONE);

  // Search key and the route that an add transaction would store.
  always_comb begin
    key.is_add         = is_add;
    key.len            = sat_len(req_q.prefix_len_in);
    key.prefix         = req_q.route_prefix_in & len_mask(key.len);
    key.dst            = req_q.dst_addr;
    new_entry.prefix   = key.prefix;
    new_entry.len      = key.len;
    new_entry.port     = req_q.port_in;
    new_entry.has_hop  = req_q.has_hop_in;
    new_entry.hop_addr = req_q.hop_addr_in;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = ttl_dead_in ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_addr_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs toward the table.
  always_comb begin
    ctl.start    = in_accept;
    ctl.rd_en    = 1'b0;
    ctl.rd_addr  = rd_addr_q;
    ctl.wr_en    = 1'b0;
    ctl.wr_addr  = res.slot;
    ctl.wr_entry = new_entry;
    rd_addr_d    = rd_addr_q;
    case (state_q)
      S_IDLE: begin
        rd_addr_d = '0;
      end
      S_SCAN: begin
        ctl.rd_en = 1'b1;
        rd_addr_d = rd_addr_q + IDX_W'(1);
      end
      S_DONE: begin
        ctl.wr_en = out_free && is_add && !res.dup && res.slot_ok;
      end
      default: begin
        rd_addr_d = rd_addr_q;
      end
    endcase
  end

  // Result of the finished transaction.
  always_comb begin
    result.status       = ST_ADDED;
    result.out_port     = '0;
    result.out_hop_addr = '0;
    result.out_ttl      = '0;
    if (is_add) begin
      if (res.dup) begin
        result.status = ST_DUP;
      end else if (!res.slot_ok) begin
        result.status = ST_FULL;
      end
    end else if (ttl_dead) begin
      result.status = ST_TTL;
    end else if (!res.found) begin
      result.status = ST_NOROUTE;
    end else begin
      result.status       = ST_FWD;
      result.out_port     = res.best.port;
      result.out_hop_addr = res.best.has_hop ? res.best.hop_addr : req_q.dst_addr;
      result.out_ttl      = req_q.ttl_in - TTL_ONE;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_addr_q <= rd_addr_d;
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q <= in_i.data;
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  iplpr_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .key_i  (key),
    .res_o  (res)
  );

endmodule

[tb/ipv4_longest_prefix_router_tb.sv]
// Self-checking testbench for the IPv4 longest-prefix route table block.
`timescale 1ns / 100ps

module ipv4_longest_prefix_router_tb;
  import iplpr_pkg::*;

  localparam int N_RANDOM       = 680;
  localparam int DEFAULT_AT     = 450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  iplpr_in_if  in_ch ();
  iplpr_out_if out_ch ();

  ipv4_longest_prefix_router dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the route table; bit types start cleared, like the block after reset.
  bit                rt_valid   [MAX_ROUTES];
  logic [ADDR_W-1:0] rt_prefix  [MAX_ROUTES];
  logic [LEN_W-1:0]  rt_len     [MAX_ROUTES];
  logic [PORT_W-1:0] rt_port    [MAX_ROUTES];
  logic              rt_has_hop [MAX_ROUTES];
  logic [ADDR_W-1:0] rt_hop     [MAX_ROUTES];

  out_t pending_results[$];

  // Directed stimulus table.
  in_t  dir_item[$];
  bit   dir_typed[$];
  out_t dir_exp[$];

  // Side information for the transaction currently offered.
  bit   cur_typed;
  out_t cur_exp;

  bit no_idle;
  int n_errors;
  int idle_cycles;

  // Network mask with the given number of leading ones.
  function automatic logic [ADDR_W-1:0] net_mask(int unsigned n);
    if (n == 0) return '0;
    if (n >= ADDR_W) return '1;
    return {ADDR_W{1'b1}} << (ADDR_W - n);
  endfunction

  // Applies one transaction to the shadow table and returns the result it must give.
  function automatic out_t route_outcome(in_t t);
    out_t        r;
    int unsigned n;
    logic [ADDR_W-1:0] key;
    bit          dup;
    int          slot;
    bit          found;
    int          best;
    r = '0;
    if (t.action == ACT_ADD) begin
      n = 32'(t.prefix_len_in);
      if (n > ADDR_W) n = ADDR_W;
      key  = t.route_prefix_in & net_mask(n);
      dup  = 1'b0;
      slot = -1;
      for (int i = 0; i < MAX_ROUTES; i++) begin
        if (rt_valid[i]) begin
          if (rt_len[i] == n && rt_prefix[i] == key) dup = 1'b1;
        end else if (slot < 0) begin
          slot = i;
        end
      end
      if (dup) begin
        r.status = ST_DUP;
      end else if (slot < 0) begin
        r.status = ST_FULL;
      end else begin
        rt_valid[slot]   = 1'b1;
        rt_prefix[slot]  = key;
        rt_len[slot]     = LEN_W'(n);
        rt_port[slot]    = t.port_in;
        rt_has_hop[slot] = t.has_hop_in;
        rt_hop[slot]     = t.hop_addr_in;
        r.status         = ST_ADDED;
      end
    end else if (t.ttl_in <= TTL_ONE) begin
      r.status = ST_TTL;
    end else begin
      found = 1'b0;
      best  = 0;
      for (int i = 0; i < MAX_ROUTES; i++) begin
        if (rt_valid[i] && (t.dst_addr & net_mask(32'(rt_len[i]))) == rt_prefix[i] &&
            (!found || rt_len[i] > rt_len[best])) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (!found) begin
        r.status = ST_NOROUTE;
      end else begin
        r.status       = ST_FWD;
        r.out_port     = rt_port[best];
        r.out_hop_addr = rt_has_hop[best] ? rt_hop[best] : t.dst_addr;
        r.out_ttl      = t.ttl_in - TTL_W'(1);
      end
    end
    return r;
  endfunction

  // Random transaction, biased toward routes that hit or extend what is stored.
  function automatic in_t gen_item(bit force_default);
    in_t         t;
    int          stored[$];
    bit          has_default;
    bit          allow_new;
    int          k;
    int unsigned pick;
    int unsigned n;
    logic [ADDR_W-1:0] m;
    t.route_prefix_in = $urandom;
    t.prefix_len_in   = LEN_W'($urandom_range(0, 63));
    t.has_hop_in      = 1'($urandom_range(0, 1));
    t.hop_addr_in     = $urandom;
    t.port_in         = PORT_W'($urandom_range(0, 7));
    t.dst_addr        = $urandom;
    t.ttl_in          = TTL_W'($urandom_range(0, 255));
    has_default = 1'b0;
    for (int i = 0; i < MAX_ROUTES; i++) begin
      if (rt_valid[i]) begin
        stored.push_back(i);
        if (rt_len[i] == 0) has_default = 1'b1;
      end
    end
    // Keep one slot free for the default route until it has been added.
    allow_new = has_default || (stored.size() < MAX_ROUTES - 1);
    k = (stored.size() > 0) ? stored[$urandom_range(0, stored.size() - 1)] : -1;
    pick = $urandom_range(0, 99);
    if (force_default) begin
      t.action        = ACT_ADD;
      t.prefix_len_in = '0;
    end else if (pick < 60) begin
      t.action = ACT_ROUTE;
      if (pick < 45 && k >= 0) begin
        m = net_mask(32'(rt_len[k]));
        t.dst_addr = rt_prefix[k] | (t.dst_addr & ~m);
      end
      if ($urandom_range(0, 9) == 0) t.ttl_in = TTL_W'($urandom_range(0, 1));
      else t.ttl_in = TTL_W'($urandom_range(2, 255));
    end else begin
      t.action = ACT_ADD;
      if (k >= 0 && (!allow_new || pick < 72)) begin
        // Same route again, with different host bits or a saturating length.
        n = 32'(rt_len[k]);
        m = net_mask(n);
        t.route_prefix_in = rt_prefix[k] | (t.route_prefix_in & ~m);
        if (n == ADDR_W && $urandom_range(0, 1)) n = $urandom_range(ADDR_W, 63);
        t.prefix_len_in = LEN_W'(n);
      end else if (k >= 0 && pick < 88) begin
        // More specific route nested under a stored one.
        n = 32'(rt_len[k]) + $urandom_range(1, 8);
        if (n > ADDR_W) n = $urandom_range(ADDR_W, 63);
        m = net_mask(32'(rt_len[k]));
        t.route_prefix_in = rt_prefix[k] | (t.route_prefix_in & ~m);
        t.prefix_len_in   = LEN_W'(n);
      end else begin
        t.prefix_len_in = LEN_W'($urandom_range(1, 63));
      end
    end
    return t;
  endfunction

  function automatic in_t mk_add(logic [ADDR_W-1:0] pfx, int unsigned n, logic hop_en,
                                 logic [ADDR_W-1:0] hop, int unsigned port);
    in_t t;
    t.action          = ACT_ADD;
    t.route_prefix_in = pfx;
    t.prefix_len_in   = LEN_W'(n);
    t.has_hop_in      = hop_en;
    t.hop_addr_in     = hop;
    t.port_in         = PORT_W'(port);
    t.dst_addr        = $urandom;
    t.ttl_in          = TTL_W'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic in_t mk_dgram(logic [ADDR_W-1:0] dst, int unsigned ttl);
    in_t t;
    t.action          = ACT_ROUTE;
    t.route_prefix_in = $urandom;
    t.prefix_len_in   = LEN_W'($urandom_range(0, 63));
    t.has_hop_in      = 1'($urandom_range(0, 1));
    t.hop_addr_in     = $urandom;
    t.port_in         = PORT_W'($urandom_range(0, 7));
    t.dst_addr        = dst;
    t.ttl_in          = TTL_W'(ttl);
    return t;
  endfunction

  // Result that carries only a status; all other fields are zero.
  function automatic out_t status_only(status_e s);
    out_t r;
    r        = '0;
    r.status = s;
    return r;
  endfunction

  task automatic add_row(in_t t, bit typed, out_t exp);
    dir_item.push_back(t);
    dir_typed.push_back(typed);
    dir_exp.push_back(exp);
  endtask

  // Waits a random gap, then offers one transaction and holds it until it is taken.
  task automatic offer(int row, bit force_default);
    int  gap;
    in_t t;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
    end
    @(negedge clk_i);
    if (row >= 0) begin
      t         = dir_item[row];
      cur_typed = dir_typed[row];
      cur_exp   = dir_exp[row];
    end else begin
      t         = gen_item(force_default);
      cur_typed = 1'b0;
      cur_exp   = '0;
    end
    in_ch.data  = t;
    in_ch.valid = 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Predicts on every accepted input and checks every accepted result.
  always @(posedge clk_i) begin : scoreboard
    out_t pred;
    out_t want;
    out_t got;
    if (in_ch.valid && in_ch.ready) begin
      pred = route_outcome(in_ch.data);
      pending_results.push_back(cur_typed ? cur_exp : pred);
    end
    if (out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: result with none pending: status=%0d port=%0d hop=%h ttl=%0d",
                   $realtime, got.status, got.out_port, got.out_hop_addr, got.out_ttl);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.out_port !== want.out_port ||
            got.out_hop_addr !== want.out_hop_addr || got.out_ttl !== want.out_ttl) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: exp st=%0d port=%0d hop=%h ttl=%0d, got st=%0d port=%0d hop=%h ttl=%0d",
                     $realtime, want.status, want.out_port, want.out_hop_addr, want.out_ttl,
                     got.status, got.out_port, got.out_hop_addr, got.out_ttl);
        end
      end
    end
    // Cycles without any transaction feed the watchdog.
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  // Watchdog on a stalled run.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Result side: random stall before each transaction.
  initial begin : result_sink
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk_i);
        out_ch.ready = 1'b0;
      end
      @(negedge clk_i);
      out_ch.ready = 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    no_idle     = 1'b0;

    // Empty table: no route, then expired TTL of zero and of one.
    add_row(mk_dgram(32'h0000_0000, 255), 1'b1, status_only(ST_NOROUTE));
    add_row(mk_dgram(32'hFFFF_FFFF, 0), 1'b1, status_only(ST_TTL));
    add_row(mk_dgram(32'h1234_5678, 1), 1'b1, status_only(ST_TTL));
    // Host bits beyond the length are masked off; an oversized length saturates.
    add_row(mk_add(32'hC0A8_FFFF, 16, 1'b0, 32'h0, 0), 1'b1, status_only(ST_ADDED));
    add_row(mk_add(32'hC0A8_0100, 24, 1'b1, 32'h0A00_0001, 3), 1'b1, status_only(ST_ADDED));
    add_row(mk_add(32'hFFFF_FFFF, 63, 1'b1, 32'hFFFF_FFFF, 7), 1'b1, status_only(ST_ADDED));
    add_row(mk_add(32'hFFFF_FFFF, 32, 1'b0, 32'h0, 1), 1'b1, status_only(ST_DUP));
    add_row(mk_add(32'hC0A8_12FF, 16, 1'b1, 32'h1, 2), 1'b1, status_only(ST_DUP));
    // Longest match among nested routes, at the TTL extremes.
    add_row(mk_dgram(32'hC0A8_0105, 2), 1'b0, '0);
    add_row(mk_dgram(32'hC0A8_0205, 255), 1'b0, '0);
    add_row(mk_dgram(32'hFFFF_FFFF, 64), 1'b0, '0);
    add_row(mk_dgram(32'hFFFF_FFFE, 2), 1'b1, status_only(ST_NOROUTE));
    // Half-space routes cover both ends of the address range.
    add_row(mk_add(32'h0000_0000, 1, 1'b1, 32'h0000_0000, 5), 1'b1, status_only(ST_ADDED));
    add_row(mk_dgram(32'h0000_0000, 2), 1'b0, '0);
    add_row(mk_dgram(32'h7FFF_FFFF, 200), 1'b0, '0);
    add_row(mk_add(32'h8000_0000, 1, 1'b1, 32'h8000_0001, 6), 1'b1, status_only(ST_ADDED));
    add_row(mk_dgram(32'hFFFF_FFFE, 3), 1'b0, '0);
    // A matching route does not save an expired datagram.
    add_row(mk_dgram(32'hC0A8_0180, 1), 1'b1, status_only(ST_TTL));
    add_row(mk_add(32'hC0A8_0180, 25, 1'b0, 32'h0, 1), 1'b1, status_only(ST_ADDED));
    add_row(mk_dgram(32'hC0A8_01FF, 10), 1'b0, '0);
    add_row(mk_dgram(32'hC0A8_017F, 10), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < dir_item.size(); r++) offer(r, 1'b0);

    // Random traffic; every third block of 100 runs without idle cycles.
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = ((i / 100) % 3) == 2;
      offer(-1, i == DEFAULT_AT);
    end
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    no_idle     = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
sv/iplpr_pkg.sv
sv/iplpr_in_if.sv
sv/iplpr_out_if.sv
sv/iplpr_table.sv
sv/ipv4_longest_prefix_router.sv
tb/ipv4_longest_prefix_router_tb.sv
